### src/zero_run_length_decoder_assert.svh
// Assertion macros for the zero run-length decoder.
// Included by modules that carry concurrent checks; needs nothing else.
`ifndef ZERO_RUN_LENGTH_DECODER_ASSERT_SVH
`define ZERO_RUN_LENGTH_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ZRLD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("zrld check failed");
// next-cycle implication
`define ZRLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("zrld check failed");
`else
`define ZRLD_ASSERT_NOW(label, clk, rst, ante, cons)
`define ZRLD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/zrld_pkg.sv
// Package for the zero run-length decoder: control byte codes and the
// control byte decode. No dependencies.
package zrld_pkg;

   localparam logic [7:0] CTRL_MIXED      = 8'h80;
   localparam logic [7:0] CTRL_ZEROS      = 8'h40;
   localparam logic [7:0] MASK_RUN        = 8'h3f;
   localparam logic [7:0] MASK_MIXED_LIT  = 8'h0f;
   localparam logic [2:0] MASK_MIXED_ZERO = 3'h7;

   localparam int RUN_W   = 6;
   localparam int COUNT_W = 16;

   typedef struct packed {
      logic [RUN_W-1:0] zeros;
      logic [RUN_W-1:0] literals;
   } ctrl_decode_type;

   function automatic ctrl_decode_type decode_ctrl(input logic [7:0] b);
      ctrl_decode_type d;
      logic [7:0]      run;
      logic [7:0]      lit;
      run = b & MASK_RUN;
      lit = b & MASK_MIXED_LIT;
      if ((b & CTRL_MIXED) != 8'h00) begin
         d.zeros    = {3'b000, b[6:4] & MASK_MIXED_ZERO};
         d.literals = lit[RUN_W-1:0];
      end else if ((b & CTRL_ZEROS) != 8'h00) begin
         d.zeros    = run[RUN_W-1:0];
         d.literals = '0;
      end else begin
         d.zeros    = '0;
         d.literals = run[RUN_W-1:0];
      end
      return d;
   endfunction

endpackage

### src/zero_run_length_decoder.sv
// Zero run-length decoder top level: sequencer, emit counter and CSR.
// Depends on zrld_pkg and zero_run_length_decoder_assert.svh.
//
// One compressed byte is taken per req transfer. While literals are pending
// the byte is passed through as one result; otherwise it is a control byte
// that loads the pending literal count and emits its zero bytes. An empty
// control byte needs no emit step; a literal is transferred, then emitted
// or dropped; a control byte with zeros is transferred, then emits them one
// by one, takes a single dropping step when the limit is already met, and
// stops early when the limit falls inside the run. Throughput is set by the
// single emit unit (one run counter, one increment and two limit compares
// of the output count) that produces at most one result per cycle, with
// req_tready low while it runs. Results sit in an output register, so a
// stalled rsp side only holds the emit unit. Once the output count reaches
// output_limit (CSR at byte address 0) further results are dropped, though
// bytes are still decoded; req_tuser set clears the count and pending
// literals ahead of its byte. No clearing pass is needed after reset.
`include "zero_run_length_decoder_assert.svh"

module zero_run_length_decoder (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] start_of_stream
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // last_of_item
   output logic        rsp_tuser,   // [0] limit_reached
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;
   localparam logic REG_OUTPUT_LIMIT = 1'b0;

   localparam int RW = zrld_pkg::RUN_W;
   localparam int CW = zrld_pkg::COUNT_W;

   logic          state_ff, state_in;
   logic [RW-1:0] lit_ff, lit_in;          // literals still expected
   logic [RW-1:0] run_ff, run_in;          // results left for this byte
   logic [7:0]    value_ff, value_in;      // byte being emitted
   logic [CW-1:0] produced_ff, produced_in;
   logic [CW-1:0] limit_ff, limit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_hit_ff, rsp_hit_in;

   logic                      req_xfer;
   logic                      csr_write;
   logic                      slot_free;
   logic                      under_limit;
   logic                      emit;
   logic                      emit_last;
   logic                      hit;
   logic [CW-1:0]             produced_next;
   logic [RW-1:0]             lit_cur;
   zrld_pkg::ctrl_decode_type dec;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_OUTPUT_LIMIT) ? {16'h0000, limit_ff} : 32'h0;

   // shared emit unit: one increment and two compares against the limit
   assign slot_free     = !rsp_valid_ff || rsp_tready;
   assign under_limit   = produced_ff < limit_ff;
   assign produced_next = produced_ff + {{(CW-1){1'b0}}, 1'b1};
   assign hit           = (produced_next == limit_ff);
   assign emit          = (state_ff == ST_RUN) && slot_free && under_limit;
   assign emit_last     = (run_ff == {{(RW-1){1'b0}}, 1'b1}) || hit;

   assign lit_cur = req_tuser ? '0 : lit_ff;
   assign dec     = zrld_pkg::decode_ctrl(req_tdata);

   always_comb begin
      state_in    = state_ff;
      lit_in      = lit_ff;
      run_in      = run_ff;
      value_in    = value_ff;
      produced_in = produced_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser) begin
                  produced_in = '0;
               end
               if (lit_cur != '0) begin
                  // pending literal: pass byte through
                  lit_in   = lit_cur - {{(RW-1){1'b0}}, 1'b1};
                  run_in   = {{(RW-1){1'b0}}, 1'b1};
                  value_in = req_tdata;
                  state_in = ST_RUN;
               end else begin
                  lit_in   = dec.literals;
                  run_in   = dec.zeros;
                  value_in = 8'h00;
                  if (dec.zeros != '0) begin
                     state_in = ST_RUN;
                  end
               end
            end
         end
         ST_RUN: begin
            if (slot_free) begin
               if (!under_limit) begin
                  // limit met: rest of the run is dropped
                  run_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  produced_in = produced_next;
                  run_in      = run_ff - {{(RW-1){1'b0}}, 1'b1};
                  if (emit_last) begin
                     run_in   = '0;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_hit_in   = rsp_hit_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = value_ff;
         rsp_last_in  = emit_last;
         rsp_hit_in   = hit;
      end
   end

   always_comb begin
      limit_in = limit_ff;
      if (csr_write && (csr_paddr[2] == REG_OUTPUT_LIMIT)) begin
         limit_in = csr_pwdata[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lit_ff       <= '0;
         run_ff       <= '0;
         produced_ff  <= '0;
         limit_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lit_ff       <= lit_in;
         run_ff       <= run_in;
         produced_ff  <= produced_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_hit_ff;

   `ZRLD_ASSERT_NOW(a_emit_has_work, clock, reset, emit, run_ff != '0)
   `ZRLD_ASSERT_NEXT(a_last_ends_run, clock, reset, emit && emit_last, state_ff == ST_IDLE)
   `ZRLD_ASSERT_NEXT(a_count_steps, clock, reset, emit, produced_ff == $past(produced_next))
   `ZRLD_ASSERT_NOW(a_idle_no_run, clock, reset, state_ff == ST_IDLE, run_ff == '0)

endmodule

### sim/tb.sv
// Self-checking bench for zero_run_length_decoder: stream driver, result monitor and APB set-up.
// Needs zrld_pkg and the decoder RTL; expected bytes come from a behavioural decoder kept here.
module tb;

   localparam logic [2:0] OUTPUT_LIMIT_ADDR = 3'd0;
   localparam int SETTLE_CYCLES = 80;      // longest zero run plus margin
   localparam int LIMIT_CYCLES  = 1000000;

   // one compressed byte as it goes over the req channel
   typedef struct packed {
      logic [7:0] code;
      logic       restart;
   } stream_byte_type;

   // one decoded byte as it should appear on the rsp channel
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       full;
   } decoded_byte_type;

   typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] in_byte
   logic        req_tuser = 1'b0; // [0] start_of_stream
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] out_byte
   logic        rsp_tlast;        // last_of_item
   logic        rsp_tuser;        // [0] limit_reached
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // behavioural decoder state, mirrors the block
   logic [5:0]  lits_left = '0;
   logic [15:0] out_count = '0;
   logic [15:0] out_limit = 16'hffff;

   stream_byte_type  stream_bytes[$];   // bytes waiting to go out
   decoded_byte_type decoded_bytes[$];  // decoded bytes still owed by the block
   stream_byte_type  byte_on_bus;

   int          items_queued = 0;
   int          errors = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_phase = 0;
   rx_mode_type rx_mode = RX_ALWAYS;

   zero_run_length_decoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // -------------------------------------------------------------------------
   // Behavioural decoder
   // -------------------------------------------------------------------------

   // Queue one output byte unless the limit is already met. A byte that fills
   // the limit is the last one the item can give, so it carries last as well.
   task automatic emit_byte(input logic [7:0] value, input logic final_of_run);
      logic hit;
      if (out_count >= out_limit)
         return;
      out_count = out_count + 16'd1;
      hit = (out_count == out_limit);
      decoded_bytes.push_back('{data: value, last: final_of_run | hit, full: hit});
   endtask

   task automatic decode_byte(input stream_byte_type sb);
      logic [5:0] zero_run;
      zero_run = '0;
      if (sb.restart) begin
         lits_left = '0;
         out_count = '0;
      end
      if (lits_left != 0) begin
         // literal pass-through
         lits_left = lits_left - 6'd1;
         emit_byte(sb.code, 1'b1);
      end else begin
         if ((sb.code & zrld_pkg::CTRL_MIXED) != 8'h00) begin
            zero_run  = {3'b000, sb.code[6:4] & zrld_pkg::MASK_MIXED_ZERO};
            lits_left = 6'(sb.code & zrld_pkg::MASK_MIXED_LIT);
         end else if ((sb.code & zrld_pkg::CTRL_ZEROS) != 8'h00) begin
            zero_run  = 6'(sb.code & zrld_pkg::MASK_RUN);
            lits_left = '0;
         end else begin
            lits_left = 6'(sb.code & zrld_pkg::MASK_RUN);
         end
         for (int k = 0; k < zero_run; k++)
            emit_byte(8'h00, k == zero_run - 1);
      end
   endtask

   // -------------------------------------------------------------------------
   // req driver: bursts of random length with random gaps; the byte is
   // decoded by the model at the edge of its transfer
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            decode_byte(byte_on_bus);
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (stream_bytes.size() != 0) begin
               byte_on_bus = stream_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= byte_on_bus.code;
               req_tuser  <= byte_on_bus.restart;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  // a quarter of bursts run straight into the next
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // rsp monitor: every transfer is checked against the oldest owed byte;
   // tready follows a stall mode (always, random, sparse or periodic) picked at random
   // -------------------------------------------------------------------------
   task automatic check_result();
      decoded_byte_type exp_byte;
      if (decoded_bytes.size() == 0) begin
         $display("%0t: unexpected result data %h last %b full %b", $time,
                  rsp_tdata, rsp_tlast, rsp_tuser);
         errors++;
         return;
      end
      exp_byte = decoded_bytes.pop_front();
      if (rsp_tdata !== exp_byte.data) begin
         $display("%0t: out_byte expected %h got %h", $time, exp_byte.data, rsp_tdata);
         errors++;
      end
      if (rsp_tlast !== exp_byte.last) begin
         $display("%0t: last_of_item expected %b got %b", $time, exp_byte.last, rsp_tlast);
         errors++;
      end
      if (rsp_tuser !== exp_byte.full) begin
         $display("%0t: limit_reached expected %b got %b", $time, exp_byte.full, rsp_tuser);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result();
         stall_phase++;
         if (stall_phase % 150 == 0)
            rx_mode = rx_mode_type'($urandom_range(0, 3));
         case (rx_mode)
            RX_ALWAYS:   rsp_tready <= 1'b1;
            RX_RANDOM:   rsp_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
            default:     rsp_tready <= ((stall_phase % 7) < 4);
         endcase
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: timeout, %0d decoded bytes still owed", $time, decoded_bytes.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] code, input logic restart);
      stream_bytes.push_back('{code: code, restart: restart});
      items_queued++;
   endtask

   // One control byte and the literals it calls for, random content. Now and
   // then a random byte or a short literal run breaks the framing.
   task automatic push_frame(input int restart_odds);
      logic [7:0] ctrl;
      int         n_lits;
      int         kind;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         n_lits = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
         ctrl   = 8'(n_lits) & zrld_pkg::MASK_RUN;
      end else if (kind < 7) begin
         ctrl   = zrld_pkg::CTRL_MIXED | 8'($urandom_range(0, 127));
         n_lits = int'(ctrl & zrld_pkg::MASK_MIXED_LIT);
      end else if (kind < 9) begin
         ctrl = zrld_pkg::CTRL_ZEROS
                | (8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 8))
                   & zrld_pkg::MASK_RUN);
         n_lits = 0;
      end else begin
         ctrl   = 8'($urandom);
         n_lits = 0;
      end
      push_byte(ctrl, $urandom_range(1, restart_odds) == 1);
      if ($urandom_range(0, 15) == 0)
         n_lits = $urandom_range(0, n_lits);
      for (int k = 0; k < n_lits; k++)
         push_byte(8'($urandom), $urandom_range(0, 63) == 0);
   endtask

   // Sampled on the falling edge so the driver's and monitor's updates at the
   // rising edge have settled. The tail covers dropped zero runs.
   task automatic wait_idle();
      do @(negedge clock);
      while (stream_bytes.size() != 0 || req_tvalid || decoded_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // APB write then read-back of output_limit; only called when idle
   task automatic write_limit(input logic [15:0] value);
      logic [31:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= OUTPUT_LIMIT_ADDR;
      csr_pwdata  <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      out_limit = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[15:0] !== value) begin
         $display("%0t: output_limit read expected %h got %h", $time, value, readback[15:0]);
         errors++;
      end
   endtask

   initial begin
      do @(negedge clock);
      while (reset);

      // reset limit: empty controls, longest zero run, literals that look
      // like controls, mixed control, restart in the middle of a literal run
      push_byte(8'h00, 1'b1);
      push_byte(zrld_pkg::CTRL_MIXED, 1'b0);
      push_byte(zrld_pkg::CTRL_ZEROS, 1'b0);
      push_byte(zrld_pkg::CTRL_ZEROS | 8'd63, 1'b0);
      push_byte(8'd3, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(zrld_pkg::CTRL_ZEROS, 1'b0);
      push_byte(zrld_pkg::CTRL_MIXED | 8'h72, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h7f, 1'b0);
      push_byte(zrld_pkg::CTRL_MIXED | 8'h01, 1'b0);
      push_byte(8'h3c, 1'b0);
      push_byte(8'd10, 1'b0);
      push_byte(8'h11, 1'b0);
      push_byte(zrld_pkg::CTRL_ZEROS | 8'd1, 1'b1);
      wait_idle();

      // zero limit: nothing may come out
      write_limit(16'h0000);
      push_byte(zrld_pkg::CTRL_ZEROS | 8'd63, 1'b1);
      push_byte(8'hff, 1'b0);
      while (items_queued < 40)
         push_frame(4);
      wait_idle();

      // small limit: truncated zero run, literals decoded but dropped, restart
      write_limit(16'd5);
      push_byte(zrld_pkg::CTRL_ZEROS | 8'd10, 1'b1);
      push_byte(8'd2, 1'b0);
      push_byte(8'haa, 1'b0);
      push_byte(8'h55, 1'b0);
      push_byte(8'd3, 1'b1);
      push_byte(8'h01, 1'b0);
      push_byte(8'hfe, 1'b0);
      push_byte(8'h7f, 1'b0);
      push_byte(zrld_pkg::CTRL_MIXED | 8'h32, 1'b0);
      push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b0);
      while (items_queued < 90)
         push_frame(3);
      wait_idle();

      write_limit(16'd1);
      while (items_queued < 120)
         push_frame(2);
      wait_idle();

      // limit written below the running count: dropped until a restart
      write_limit(16'hffff);
      push_byte(zrld_pkg::CTRL_ZEROS | 8'd10, 1'b1);
      wait_idle();
      write_limit(16'd3);
      push_byte(zrld_pkg::CTRL_ZEROS | 8'd5, 1'b0);
      push_byte(8'd2, 1'b0);
      push_byte(8'h11, 1'b0);
      push_byte(8'h22, 1'b0);
      push_byte(zrld_pkg::CTRL_MIXED | 8'h83, 1'b0);
      while (items_queued < 160)
         push_frame(3);
      wait_idle();

      // main random run at full limit, with one full drain half way
      write_limit(16'hffff);
      while (items_queued < 300)
         push_frame(20);
      wait_idle();
      while (items_queued < 400)
         push_frame(20);
      wait_idle();

      write_limit(16'd20);
      while (items_queued < 440)
         push_frame(5);
      wait_idle();

      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
